[hw/rtl/crast_pkg.sv]
// Package for the circle rasterizer core: transfer payload types, request mode codes
// and the result index limits of one step. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package crast_pkg;

   // Fixed widths of the transfer fields.
   localparam int IN_BITS  = 14;
   localparam int OUT_BITS = 16;
   localparam int IDX_BITS = 3;

   // Request mode codes.
   localparam logic [1:0] MODE_OUTLINE = 2'd0;
   localparam logic [1:0] MODE_FILL    = 2'd1;
   localparam logic [1:0] MODE_ADVANCE = 2'd2;

   // Index of the final result of one step.
   localparam logic [IDX_BITS-1:0] LAST_IDX_OUTLINE = 3'd7;
   localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = 3'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic [IN_BITS-1:0]  center_x;
      logic [IN_BITS-1:0]  center_y;
      logic [IN_BITS-1:0]  radius;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] pixel_x;
      logic signed [OUT_BITS-1:0] pixel_y;
      logic signed [OUT_BITS-1:0] span_end_x;
      logic                       last;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/circle_rasterizer_core.sv]
// A request transfer loads the step buffer, which sends one result a cycle, while the output is
// not stalled, through the result register. A step has eight results in outline mode, four in
// fill mode, over the single result channel; the next request is taken in the cycle that sends
// the step's final result. Requests with no result (advance while idle, unused mode) load no step.
// Reset: synchronous, active high; clears circle state, buffer valid and index, and result valid.
`timescale 1ns / 1ps
`default_nettype none

module circle_rasterizer_core #(
   parameter int COORD_BITS = 14
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire crast_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output crast_pkg::rsp_type     rsp_data
);

   // Widths: centre coordinates, step offsets (one bit more for the offset that can
   // reach the radius plus one) and the decision value (room for 4*(x-y)+10 swings).
   localparam int CW = COORD_BITS;
   localparam int SW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 4;
   localparam int OW = crast_pkg::OUT_BITS;
   localparam int IW = crast_pkg::IDX_BITS;

   // Circle state, updated at the request transfer that causes a step.
   logic [CW-1:0] origin_col_ff, origin_col_in;
   logic [CW-1:0] origin_row_ff, origin_row_in;
   logic [SW-1:0] step_x_ff, step_x_in;
   logic [SW-1:0] step_y_ff, step_y_in;
   logic [DW-1:0] decision_ff, decision_in;   // two's complement, sign in the top bit
   logic          fill_on_ff, fill_on_in;
   logic          busy_ff, busy_in;

   // Step buffer: the offsets of the step being sent out, one result per cycle while not stalled.
   logic          snap_vld_ff, snap_vld_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] snap_cx_ff, snap_cx_in;
   logic [CW-1:0] snap_cy_ff, snap_cy_in;
   logic [SW-1:0] snap_x_ff, snap_x_in;
   logic [SW-1:0] snap_y_ff, snap_y_in;
   logic          snap_fill_ff, snap_fill_in;
   logic          snap_done_ff, snap_done_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   crast_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // Step computation signals.
   logic          req_go, is_start, is_adv, does_step;
   logic [CW-1:0] cur_cx, cur_cy, rad;
   logic [SW-1:0] cur_x, cur_y;
   logic [DW-1:0] cur_d, x4, y4;
   logic          dec_neg, cur_fill, done;
   logic [SW:0]   y_wide, x_wide;

   // Result selection signals.
   logic          emit_go, at_last, swap, negx, negy;
   logic [IW-1:0] last_idx;
   logic [SW-1:0] off_a, off_b;
   logic [OW-1:0] cx16, cy16, a16, b16, px16, py16, ex16;

   always_comb begin
      req_go   = req_valid && req_ready;
      is_start = (req_data.mode == crast_pkg::MODE_OUTLINE) ||
                 (req_data.mode == crast_pkg::MODE_FILL);
      is_adv   = (req_data.mode == crast_pkg::MODE_ADVANCE) && busy_ff;
      does_step = is_start || is_adv;

      // A start step works from the request fields, an advance from the stored state.
      rad      = CW'(req_data.radius);
      cur_cx   = is_start ? CW'(req_data.center_x) : origin_col_ff;
      cur_cy   = is_start ? CW'(req_data.center_y) : origin_row_ff;
      cur_x    = is_start ? '0 : step_x_ff;
      cur_y    = is_start ? SW'(rad) : step_y_ff;
      cur_d    = is_start ? (DW'(3) - (DW'(rad) << 1)) : decision_ff;
      cur_fill = is_start ? (req_data.mode == crast_pkg::MODE_FILL) : fill_on_ff;

      // Midpoint decision update.
      x4      = DW'(cur_x) << 2;
      y4      = DW'(cur_y) << 2;
      dec_neg = cur_d[DW-1];
      x_wide  = {1'b0, cur_x};
      y_wide  = {1'b0, cur_y};
      if (dec_neg) begin
         decision_in = cur_d + x4 + DW'(6);
         step_y_in   = cur_y;
         // New y equals y, new x equals x + 1.
         done        = y_wide < (x_wide + (SW+1)'(1));
      end else begin
         decision_in = cur_d + (x4 - y4) + DW'(10);
         step_y_in   = cur_y - SW'(1);
         // Compared before the decrement so that a zero radius cannot wrap.
         done        = y_wide < (x_wide + (SW+1)'(2));
      end
      step_x_in = cur_x + SW'(1);

      origin_col_in = origin_col_ff;
      origin_row_in = origin_row_ff;
      fill_on_in    = fill_on_ff;
      busy_in       = busy_ff;
      if (!(req_go && does_step)) begin
         decision_in = decision_ff;
         step_x_in   = step_x_ff;
         step_y_in   = step_y_ff;
      end else begin
         origin_col_in = cur_cx;
         origin_row_in = cur_cy;
         fill_on_in    = cur_fill;
         busy_in       = !done;
      end
   end

   // Result sequencing: the buffer sends one result into the output register whenever
   // that register is empty or being drained in the same cycle.
   always_comb begin
      last_idx  = snap_fill_ff ? crast_pkg::LAST_IDX_FILL : crast_pkg::LAST_IDX_OUTLINE;
      at_last   = (idx_ff == last_idx);
      emit_go   = snap_vld_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !snap_vld_ff || (emit_go && at_last);

      snap_vld_in  = snap_vld_ff;
      idx_in       = idx_ff;
      snap_cx_in   = snap_cx_ff;
      snap_cy_in   = snap_cy_ff;
      snap_x_in    = snap_x_ff;
      snap_y_in    = snap_y_ff;
      snap_fill_in = snap_fill_ff;
      snap_done_in = snap_done_ff;
      if (req_go && does_step) begin
         snap_vld_in  = 1'b1;
         idx_in       = '0;
         snap_cx_in   = cur_cx;
         snap_cy_in   = cur_cy;
         snap_x_in    = cur_x;
         snap_y_in    = cur_y;
         snap_fill_in = cur_fill;
         snap_done_in = done;
      end else if (emit_go) begin
         if (at_last) begin
            snap_vld_in = 1'b0;
         end
         idx_in = idx_ff + IW'(1);
      end
   end

   // One result of the buffered step. Outline order: index bit 0 swaps the offsets,
   // bit 1 mirrors the column, bit 2 mirrors the row. Fill order: index bit 1 swaps,
   // bit 0 picks the lower row, and each span runs one column past the mirror.
   always_comb begin
      if (snap_fill_ff) begin
         swap = idx_ff[1];
         negx = 1'b1;
         negy = !idx_ff[0];
      end else begin
         swap = idx_ff[0];
         negx = idx_ff[1];
         negy = idx_ff[2];
      end
      off_a = swap ? snap_y_ff : snap_x_ff;
      off_b = swap ? snap_x_ff : snap_y_ff;
      // Coordinates wrap to the output width, so the sums are formed at that width.
      cx16  = OW'(snap_cx_ff);
      cy16  = OW'(snap_cy_ff);
      a16   = OW'(off_a);
      b16   = OW'(off_b);
      px16  = negx ? (cx16 - a16) : (cx16 + a16);
      py16  = negy ? (cy16 - b16) : (cy16 + b16);
      ex16  = snap_fill_ff ? (cx16 + a16 + OW'(1)) : px16;

      rsp_data_in.pixel_x    = px16;
      rsp_data_in.pixel_y    = py16;
      rsp_data_in.span_end_x = ex16;
      rsp_data_in.last       = snap_done_ff && at_last;

      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= '0;
         origin_row_ff <= '0;
         step_x_ff     <= '0;
         step_y_ff     <= '0;
         decision_ff   <= '0;
         fill_on_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         snap_vld_ff   <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         origin_col_ff <= origin_col_in;
         origin_row_ff <= origin_row_in;
         step_x_ff     <= step_x_in;
         step_y_ff     <= step_y_in;
         decision_ff   <= decision_in;
         fill_on_ff    <= fill_on_in;
         busy_ff       <= busy_in;
         snap_vld_ff   <= snap_vld_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers hold their value until the next load.
   always_ff @(posedge clock) begin
      snap_cx_ff   <= snap_cx_in;
      snap_cy_ff   <= snap_cy_in;
      snap_x_ff    <= snap_x_in;
      snap_y_ff    <= snap_y_in;
      snap_fill_ff <= snap_fill_in;
      snap_done_ff <= snap_done_in;
      if (emit_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/crast_checker.sv]
// Port-level checks for the circle rasterizer core, attached to it by a bind statement.
// Depends on crast_pkg for the transfer types and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module crast_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire crast_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire crast_pkg::rsp_type rsp_data
);

   // A stalled result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Requests are held off only while a step is being sent, so a result follows.
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> rsp_valid)
      else $error("request stalled with no result on the way");

   // A start transfer shows a valid result once the step buffer and then the result register load.
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.mode == crast_pkg::MODE_OUTLINE || req_data.mode == crast_pkg::MODE_FILL)
      |-> ##2 rsp_valid)
      else $error("start request produced no result");

   // Reset empties the result register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind circle_rasterizer_core crast_checker u_crast_checker (.*);

`default_nettype wire
